@@ hw/rtl/brd_pkg.sv @@
// Shared types and constants for the byte ring deque.
package brd_pkg;

  localparam int unsigned OP_W              = 2;
  localparam int unsigned BYTE_W            = 8;
  localparam int unsigned LEN_W             = 9;
  localparam int unsigned MAX_DEPTH_DEFAULT = 256;
  localparam logic [LEN_W-1:0] RING_LENGTH_RESET = 9'd256;

  typedef enum logic [OP_W-1:0] {
    OP_GET    = 2'd0,
    OP_PUT    = 2'd1,
    OP_ERASE  = 2'd2,
    OP_INSERT = 2'd3
  } op_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  typedef struct packed {
    logic             byte_sel;
    logic             done_res;
    logic [LEN_W-1:0] fill_count;
    logic             is_empty;
    logic             is_full;
  } res_t;

endpackage

@@ hw/rtl/brd_in_if.sv @@
// Input channel: one deque operation per transaction.
interface brd_in_if;
  logic                        valid;
  logic                        ready;
  logic [brd_pkg::OP_W-1:0]    opcode;
  logic [brd_pkg::BYTE_W-1:0]  byte_in;

  modport source (output valid, output opcode, output byte_in, input ready);
  modport sink   (input valid, input opcode, input byte_in, output ready);
endinterface

@@ hw/rtl/brd_out_if.sv @@
// Output channel: one operation result per transaction.
interface brd_out_if;
  logic                        valid;
  logic                        ready;
  logic [brd_pkg::BYTE_W-1:0]  byte_out;
  logic                        done_res;
  logic [brd_pkg::LEN_W-1:0]   fill_count;
  logic                        is_empty;
  logic                        is_full;

  modport source (output valid, output byte_out, output done_res, output fill_count,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input byte_out, input done_res, input fill_count,
                  input is_empty, input is_full, output ready);
endinterface

@@ hw/rtl/brd_ring_mem.sv @@
// Single-port ring store with registered read data.
module brd_ring_mem #(
  parameter int unsigned DEPTH  = brd_pkg::MAX_DEPTH_DEFAULT,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  brd_pkg::mem_ctl_t          ctl_i,
  input  logic [ADDR_W-1:0]          addr_i,
  input  logic [brd_pkg::BYTE_W-1:0] wdata_i,
  output logic [brd_pkg::BYTE_W-1:0] rdata_o
);

  logic [brd_pkg::BYTE_W-1:0] mem_q [DEPTH];
  logic [brd_pkg::BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/brd_ctrl.sv @@
// Index, count and length control with the ring store access and result registers.
module brd_ctrl #(
  parameter int unsigned MAX_DEPTH = brd_pkg::MAX_DEPTH_DEFAULT,
  parameter int unsigned IDX_W     = $clog2(MAX_DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [brd_pkg::OP_W-1:0]   opcode_i,
  input  logic [brd_pkg::BYTE_W-1:0] byte_in_i,
  input  logic                       cfg_we_i,
  input  logic [brd_pkg::LEN_W-1:0]  cfg_wdata_i,
  output brd_pkg::mem_ctl_t          mem_ctl_o,
  output logic [IDX_W-1:0]           mem_addr_o,
  output logic [brd_pkg::BYTE_W-1:0] mem_wdata_o,
  output brd_pkg::res_t              res_o
);

  localparam int unsigned LEN_W = brd_pkg::LEN_W;

  logic [IDX_W-1:0] front_q, front_d, back_q, back_d;
  logic [LEN_W-1:0] count_q, count_d, len_q;
  brd_pkg::res_t    res_q, res_d;

  logic [LEN_W-1:0] len_eff;
  logic [IDX_W-1:0] front_w, back_w, front_inc, front_dec, back_inc, back_dec;
  logic             not_empty, not_full, rd, wr, ok;
  brd_pkg::op_e     op;

  always_comb begin
    if (len_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(len_q) > MAX_DEPTH) begin
      len_eff = LEN_W'(MAX_DEPTH);
    end else begin
      len_eff = len_q;
    end
  end

  assign front_w   = (32'(front_q) >= 32'(len_eff)) ? '0 : front_q;
  assign back_w    = (32'(back_q) >= 32'(len_eff)) ? '0 : back_q;
  assign front_inc = (32'(front_w) + 32'd1 >= 32'(len_eff)) ? '0 : front_w + IDX_W'(1);
  assign back_inc  = (32'(back_w) + 32'd1 >= 32'(len_eff)) ? '0 : back_w + IDX_W'(1);
  assign front_dec = (front_w == '0) ? IDX_W'(len_eff - LEN_W'(1)) : front_w - IDX_W'(1);
  assign back_dec  = (back_w == '0) ? IDX_W'(len_eff - LEN_W'(1)) : back_w - IDX_W'(1);
  assign not_empty = (count_q != '0);
  assign not_full  = (count_q < len_eff);
  assign op        = brd_pkg::op_e'(opcode_i);

  always_comb begin
    front_d    = front_w;
    back_d     = back_w;
    count_d    = count_q;
    rd         = 1'b0;
    wr         = 1'b0;
    ok         = 1'b0;
    mem_addr_o = front_w;
    unique case (op)
      brd_pkg::OP_GET: begin
        ok         = not_empty;
        rd         = not_empty;
        mem_addr_o = front_w;
        if (not_empty) begin
          front_d = front_inc;
          count_d = count_q - LEN_W'(1);
        end
      end
      brd_pkg::OP_PUT: begin
        ok         = not_full;
        wr         = not_full;
        mem_addr_o = back_w;
        if (not_full) begin
          back_d  = back_inc;
          count_d = count_q + LEN_W'(1);
        end
      end
      brd_pkg::OP_ERASE: begin
        ok         = not_empty;
        rd         = not_empty;
        mem_addr_o = back_dec;
        if (not_empty) begin
          back_d  = back_dec;
          count_d = count_q - LEN_W'(1);
        end
      end
      brd_pkg::OP_INSERT: begin
        ok         = not_full;
        wr         = not_full;
        mem_addr_o = front_dec;
        if (not_full) begin
          front_d = front_dec;
          count_d = count_q + LEN_W'(1);
        end
      end
    endcase
  end

  assign mem_ctl_o.wr_en = accept_i && wr;
  assign mem_ctl_o.rd_en = accept_i && rd;
  assign mem_wdata_o     = byte_in_i;

  always_comb begin
    res_d.byte_sel   = rd;
    res_d.done_res   = ok;
    res_d.fill_count = count_d;
    res_d.is_empty   = (count_d == '0);
    res_d.is_full    = (count_d == len_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      back_q  <= '0;
      count_q <= '0;
      len_q   <= brd_pkg::RING_LENGTH_RESET;
    end else if (cfg_we_i) begin
      front_q <= '0;
      back_q  <= '0;
      count_q <= '0;
      len_q   <= cfg_wdata_i;
    end else if (accept_i) begin
      front_q <= front_d;
      back_q  <= back_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

@@ hw/rtl/byte_ring_deque_unit.sv @@
// Top level of the byte ring deque: handshake, output register and ring store.
//
//  channel   dir  handshake      payload
//  in_i      in   valid/ready    opcode, byte_in
//  out_o     out  valid/ready    byte_out, done_res, fill_count, is_empty, is_full
//  cfg       in   cfg_we_i       cfg_wdata_i (ring_length)
//
//  One operation per cycle while results are drained; the result appears the cycle after acceptance, set by
//  the registered read of the single-port ring store.
//  A new operation is taken while the result register is empty or being drained.
//  Reset and length writes empty the queue at once; the store is not cleared.
module byte_ring_deque_unit #(
  parameter int unsigned MAX_DEPTH = brd_pkg::MAX_DEPTH_DEFAULT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [brd_pkg::LEN_W-1:0] cfg_wdata_i,
  brd_in_if.sink                    in_i,
  brd_out_if.source                 out_o
);

  localparam int unsigned IDX_W = $clog2(MAX_DEPTH);

  logic                       accept;
  logic                       out_valid_q, out_valid_d;
  brd_pkg::mem_ctl_t          mem_ctl;
  logic [IDX_W-1:0]           mem_addr;
  logic [brd_pkg::BYTE_W-1:0] mem_wdata, mem_rdata;
  brd_pkg::res_t              res;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  brd_ctrl #(
    .MAX_DEPTH (MAX_DEPTH),
    .IDX_W     (IDX_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .opcode_i    (in_i.opcode),
    .byte_in_i   (in_i.byte_in),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mem_ctl_o   (mem_ctl),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .res_o       (res)
  );

  brd_ring_mem #(
    .DEPTH  (MAX_DEPTH),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign out_o.valid      = out_valid_q;
  assign out_o.byte_out   = res.byte_sel ? mem_rdata : '0;
  assign out_o.done_res   = res.done_res;
  assign out_o.fill_count = res.fill_count;
  assign out_o.is_empty   = res.is_empty;
  assign out_o.is_full    = res.is_full;

endmodule

@@ sim/byte_ring_deque_unit_tb.sv @@
// Self-checking testbench for the byte ring deque: directed and random deque traffic with predicted results.
module byte_ring_deque_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    brd_pkg::op_e              op;
    logic [brd_pkg::BYTE_W-1:0] val;
  } deque_op_t;

  typedef struct packed {
    logic [brd_pkg::BYTE_W-1:0] byte_out;
    logic                       done_res;
    logic [brd_pkg::LEN_W-1:0]  fill_count;
    logic                       is_empty;
    logic                       is_full;
  } deque_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [brd_pkg::LEN_W-1:0] cfg_wdata = '0;

  brd_in_if  op_ch ();
  brd_out_if res_ch ();

  byte_ring_deque_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (op_ch),
    .out_o       (res_ch)
  );

  // predicted deque state
  logic [brd_pkg::BYTE_W-1:0] ring_copy [brd_pkg::MAX_DEPTH_DEFAULT];
  int                         head_idx = 0;
  int                         tail_idx = 0;
  int                         held = 0;
  logic [brd_pkg::LEN_W-1:0]  ring_len_reg = brd_pkg::RING_LENGTH_RESET;

  deque_op_t     pending_ops [$];
  deque_result_t awaited_results [$];
  int            ops_queued = 0;
  int            results_seen = 0;
  int            fail_count = 0;
  bit            op_taken = 1'b0;
  bit            res_taken = 1'b0;
  bit            send_idle = 1'b0;
  bit            sink_idle = 1'b0;
  int            op_gap = 0;
  int            res_stall = 0;

  initial begin
    op_ch.valid   = 1'b0;
    op_ch.opcode  = '0;
    op_ch.byte_in = '0;
    res_ch.ready  = 1'b0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic deque_result_t run_deque_op(brd_pkg::op_e op,
                                                 logic [brd_pkg::BYTE_W-1:0] val);
    deque_result_t r;
    int            len;
    len = (ring_len_reg == 0) ? 1 :
          (ring_len_reg > brd_pkg::MAX_DEPTH_DEFAULT) ? brd_pkg::MAX_DEPTH_DEFAULT :
          int'(ring_len_reg);
    r = '0;
    if (head_idx >= len) head_idx = 0;
    if (tail_idx >= len) tail_idx = 0;
    case (op)
      brd_pkg::OP_GET: begin
        if (held != 0) begin
          r.byte_out = ring_copy[head_idx];
          head_idx   = (head_idx + 1 >= len) ? 0 : head_idx + 1;
          held--;
          r.done_res = 1'b1;
        end
      end
      brd_pkg::OP_PUT: begin
        if (held < len) begin
          ring_copy[tail_idx] = val;
          tail_idx = (tail_idx + 1 >= len) ? 0 : tail_idx + 1;
          held++;
          r.done_res = 1'b1;
        end
      end
      brd_pkg::OP_ERASE: begin
        if (held != 0) begin
          tail_idx   = (tail_idx == 0) ? len - 1 : tail_idx - 1;
          r.byte_out = ring_copy[tail_idx];
          held--;
          r.done_res = 1'b1;
        end
      end
      default: begin
        if (held < len) begin
          head_idx = (head_idx == 0) ? len - 1 : head_idx - 1;
          ring_copy[head_idx] = val;
          held++;
          r.done_res = 1'b1;
        end
      end
    endcase
    r.fill_count = brd_pkg::LEN_W'(held);
    r.is_empty   = (held == 0);
    r.is_full    = (held == len);
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    deque_result_t want;
    if (rst_n) begin
      if (cfg_we) begin
        ring_len_reg = cfg_wdata;
        head_idx     = 0;
        tail_idx     = 0;
        held         = 0;
      end
      if (res_ch.valid && res_ch.ready) begin
        res_taken = 1'b1;
        results_seen++;
        if (awaited_results.size() == 0) begin
          $error("result transaction with no operation outstanding");
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("byte_out", 16'(want.byte_out), 16'(res_ch.byte_out));
          check_field("done_res", 16'(want.done_res), 16'(res_ch.done_res));
          check_field("fill_count", 16'(want.fill_count), 16'(res_ch.fill_count));
          check_field("is_empty", 16'(want.is_empty), 16'(res_ch.is_empty));
          check_field("is_full", 16'(want.is_full), 16'(res_ch.is_full));
        end
      end
      if (op_ch.valid && op_ch.ready) begin
        op_taken = 1'b1;
        awaited_results.push_back(run_deque_op(brd_pkg::op_e'(op_ch.opcode),
                                               op_ch.byte_in));
      end
    end
  end

  always @(negedge clk) begin : driver
    deque_op_t nxt;
    logic      vld;
    vld = op_ch.valid;
    if (vld && op_taken) begin
      vld      = 1'b0;
      op_taken = 1'b0;
    end
    if (!vld && rst_n) begin
      if (op_gap > 0) begin
        op_gap--;
      end else if (pending_ops.size() > 0) begin
        nxt = pending_ops.pop_front();
        op_ch.opcode  <= nxt.op;
        op_ch.byte_in <= nxt.val;
        vld    = 1'b1;
        op_gap = send_idle ? $urandom_range(0, 17) : 0;
      end
    end
    op_ch.valid <= vld;
  end

  always @(negedge clk) begin : sink
    if (res_taken) begin
      res_taken = 1'b0;
      res_stall = sink_idle ? $urandom_range(0, 17) : 0;
    end
    if (res_stall > 0) begin
      res_stall--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  task automatic push_op(brd_pkg::op_e op, logic [brd_pkg::BYTE_W-1:0] val);
    deque_op_t t;
    t.op  = op;
    t.val = val;
    pending_ops.push_back(t);
    ops_queued++;
  endtask

  task automatic feed_ops(int n, int add_pct);
    bit add_kind;
    repeat (n) begin
      add_kind = ($urandom_range(1, 100) <= add_pct);
      if (add_kind) begin
        push_op($urandom_range(0, 1) ? brd_pkg::OP_PUT : brd_pkg::OP_INSERT,
                brd_pkg::BYTE_W'($urandom));
      end else begin
        push_op($urandom_range(0, 1) ? brd_pkg::OP_GET : brd_pkg::OP_ERASE,
                brd_pkg::BYTE_W'($urandom));
      end
    end
  endtask

  task automatic settle();
    while (results_seen < ops_queued) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_ring_length(logic [brd_pkg::LEN_W-1:0] v);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    logic [brd_pkg::LEN_W-1:0] len_plan [8];
    len_plan = '{9'd2, 9'd3, 9'd7, 9'd300, 9'd1, 9'd16,
                 brd_pkg::LEN_W'($urandom_range(1, 511)),
                 brd_pkg::LEN_W'($urandom_range(2, 20))};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_idle = $urandom_range(0, 1);
    sink_idle = $urandom_range(0, 1);

    push_op(brd_pkg::OP_GET, 8'h00);
    push_op(brd_pkg::OP_ERASE, 8'hff);
    push_op(brd_pkg::OP_PUT, 8'h00);
    push_op(brd_pkg::OP_PUT, 8'hff);
    push_op(brd_pkg::OP_INSERT, 8'h80);
    push_op(brd_pkg::OP_INSERT, 8'h7f);
    push_op(brd_pkg::OP_GET, 8'h00);
    push_op(brd_pkg::OP_ERASE, 8'h00);
    push_op(brd_pkg::OP_GET, 8'h00);
    push_op(brd_pkg::OP_GET, 8'h00);
    push_op(brd_pkg::OP_GET, 8'h00);

    write_ring_length(9'd1);
    push_op(brd_pkg::OP_PUT, 8'h5a);
    push_op(brd_pkg::OP_PUT, 8'ha5);
    push_op(brd_pkg::OP_INSERT, 8'h33);
    push_op(brd_pkg::OP_ERASE, 8'h00);
    push_op(brd_pkg::OP_INSERT, 8'hc3);
    push_op(brd_pkg::OP_GET, 8'h00);

    write_ring_length(9'd0);
    push_op(brd_pkg::OP_PUT, 8'h01);
    push_op(brd_pkg::OP_INSERT, 8'h02);
    push_op(brd_pkg::OP_GET, 8'h00);

    write_ring_length(9'h1ff);
    push_op(brd_pkg::OP_PUT, 8'h10);
    push_op(brd_pkg::OP_INSERT, 8'h20);
    push_op(brd_pkg::OP_ERASE, 8'h00);
    push_op(brd_pkg::OP_ERASE, 8'h00);
    push_op(brd_pkg::OP_ERASE, 8'h00);

    // fill the full-size ring past capacity, then drain part of it
    write_ring_length(9'd256);
    send_idle = $urandom_range(0, 1);
    sink_idle = $urandom_range(0, 1);
    feed_ops(140, 100);
    settle();
    feed_ops(122, 100);
    feed_ops(30, 25);

    foreach (len_plan[i]) begin
      write_ring_length(len_plan[i]);
      send_idle = $urandom_range(0, 2) != 0;
      sink_idle = $urandom_range(0, 2) != 0;
      feed_ops(8, 65);
      settle();
      feed_ops(8, 35);
    end

    settle();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/brd_pkg.sv
hw/rtl/brd_in_if.sv
hw/rtl/brd_out_if.sv
hw/rtl/brd_ring_mem.sv
hw/rtl/brd_ctrl.sv
hw/rtl/byte_ring_deque_unit.sv
sim/byte_ring_deque_unit_tb.sv
